/* design/substring_occurrence_finder_unit_defines.svh */
// Assertion macros used by the checker file.
`ifndef SUBSTRING_OCCURRENCE_FINDER_UNIT_DEFINES_SVH
`define SUBSTRING_OCCURRENCE_FINDER_UNIT_DEFINES_SVH

// Clocked on clock, disabled while reset is high.
`define SOFU_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("sofu assertion failed");

// Clocked on clock, also checked through reset.
`define SOFU_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("sofu assertion failed");

`endif

/* design/sofu_pkg.sv */
package sofu_pkg;

   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_END  = 1'b1;

   localparam logic MODE_NTH  = 1'b0;
   localparam logic MODE_LAST = 1'b1;

   localparam int CSR_INDEX_BITS = 4;

   localparam logic [CSR_INDEX_BITS-1:0] REG_PATTERN_BYTES     = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PATTERN_LENGTH    = 4'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_TARGET_OCCURRENCE = 4'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SEARCH_MODE       = 4'd3;

   typedef struct packed {
      logic       command;
      logic [7:0] text_byte;
   } req_type;

   typedef struct packed {
      logic        found;
      logic [15:0] start_position;
      logic        too_long;
   } rsp_type;

   typedef struct packed {
      logic [63:0] pattern_bytes;
      logic [3:0]  pattern_length;
      logic [15:0] target_occurrence;
      logic        search_mode;
   } cfg_type;

endpackage

/* design/sofu_csr.sv */
module sofu_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [sofu_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [63:0]                           csr_wdata,
   output sofu_pkg::cfg_type                     cfg
);

   sofu_pkg::cfg_type cfg_ff;
   sofu_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            sofu_pkg::REG_PATTERN_BYTES:     cfg_in.pattern_bytes     = csr_wdata;
            sofu_pkg::REG_PATTERN_LENGTH:    cfg_in.pattern_length    = csr_wdata[3:0];
            sofu_pkg::REG_TARGET_OCCURRENCE: cfg_in.target_occurrence = csr_wdata[15:0];
            sofu_pkg::REG_SEARCH_MODE:       cfg_in.search_mode       = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pattern_bytes     <= 64'd0;
         cfg_ff.pattern_length    <= 4'd1;
         cfg_ff.target_occurrence <= 16'd1;
         cfg_ff.search_mode       <= sofu_pkg::MODE_NTH;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* design/sofu_match.sv */
module sofu_match #(
   parameter int MAX_PATTERN_BYTES = 8
) (
   input  logic [8*MAX_PATTERN_BYTES-1:0] window,
   input  logic [63:0]                    pattern_bytes,
   input  logic [3:0]                     eff_len,
   output logic                           match
);

   logic [MAX_PATTERN_BYTES-1:0] len_hit;
   logic [MAX_PATTERN_BYTES-1:0] len_sel;

   for (genvar l = 1; l <= MAX_PATTERN_BYTES; l++) begin : g_len
      always_comb begin
         len_hit[l-1] = 1'b1;
         for (int j = 0; j < l; j++) begin
            if (window[8*(l-1-j) +: 8] != pattern_bytes[8*j +: 8]) begin
               len_hit[l-1] = 1'b0;
            end
         end
      end
      assign len_sel[l-1] = (eff_len == 4'(l));
   end

   assign match = |(len_hit & len_sel);

endmodule

/* design/substring_occurrence_finder_unit.sv */
// Streaming substring finder. One word is taken per clock unless a waiting result holds it back:
// each text byte is compared against the configured pattern (1 to MAX_PATTERN_BYTES bytes,
// overlapping matches counted) combinationally between the input register and the per-string
// state registers. Text bytes give no result. An end-of-string word passes through the input
// register, then the result register, to show its result word on the outputs, and clears the
// per-string state; a result word waiting on rsp_ready holds back only a following
// end-of-string word. search_mode selects the nth occurrence (target_occurrence, 0 acts as 1)
// or the last one. Bytes beyond 2^POSITION_BITS-1 are dropped and flagged as too_long.
// Write configuration only while idle.
module substring_occurrence_finder_unit #(
   parameter int MAX_PATTERN_BYTES = 8,
   parameter int POSITION_BITS     = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  sofu_pkg::req_type                   req_word,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output sofu_pkg::rsp_type                   rsp_word,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [sofu_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [63:0]                         csr_wdata
);

   localparam int WIN_W = 8 * MAX_PATTERN_BYTES;
   localparam logic [3:0] MAX_LEN = 4'(MAX_PATTERN_BYTES);
   localparam logic [POSITION_BITS-1:0] POS_LIMIT = '1;

   sofu_pkg::cfg_type cfg;

   logic              in_valid_ff, in_valid_in;
   sofu_pkg::req_type in_word_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   sofu_pkg::rsp_type rsp_word_ff, rsp_word_in;

   logic [WIN_W-1:0]         hist_ff, hist_in;
   logic [POSITION_BITS-1:0] seen_ff, seen_in;
   logic [15:0]              occ_ff, occ_in;
   logic                     hit_ff, hit_in;
   logic [POSITION_BITS-1:0] hit_pos_ff, hit_pos_in;
   logic                     ovf_ff, ovf_in;

   logic                     advance;
   logic                     is_end;
   logic [WIN_W+7:0]         shifted;
   logic [WIN_W-1:0]         window;
   logic [3:0]               eff_len;
   logic [POSITION_BITS-1:0] len_less_one;
   logic                     cmp_match;
   logic                     match;
   logic [POSITION_BITS-1:0] start;
   logic [15:0]              occ_next;
   logic [15:0]              target;
   logic [POSITION_BITS+15:0] pos_wide;

   sofu_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   assign is_end    = (in_word_ff.command == sofu_pkg::CMD_END);
   assign advance   = in_valid_ff && !(is_end && rsp_valid_ff && !rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   assign shifted = {hist_ff, in_word_ff.text_byte};
   assign window  = shifted[WIN_W-1:0];

   always_comb begin
      if (cfg.pattern_length == 4'd0) begin
         eff_len = 4'd1;
      end else if (cfg.pattern_length > MAX_LEN) begin
         eff_len = MAX_LEN;
      end else begin
         eff_len = cfg.pattern_length;
      end
   end

   assign len_less_one = POSITION_BITS'(eff_len - 4'd1);

   sofu_match #(
      .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
   ) u_match (
      .window        (window),
      .pattern_bytes (cfg.pattern_bytes),
      .eff_len       (eff_len),
      .match         (cmp_match)
   );

   assign match    = cmp_match && (seen_ff >= len_less_one);
   assign start    = seen_ff - len_less_one;
   assign occ_next = (occ_ff == 16'hFFFF) ? occ_ff : occ_ff + 16'd1;
   assign target   = (cfg.target_occurrence == 16'd0) ? 16'd1 : cfg.target_occurrence;
   assign pos_wide = {16'd0, hit_pos_ff};

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance && is_end) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      rsp_word_in.found          = hit_ff;
      rsp_word_in.start_position = hit_ff ? pos_wide[15:0] : 16'd0;
      rsp_word_in.too_long       = ovf_ff;
   end

   always_comb begin
      hist_in    = hist_ff;
      seen_in    = seen_ff;
      occ_in     = occ_ff;
      hit_in     = hit_ff;
      hit_pos_in = hit_pos_ff;
      ovf_in     = ovf_ff;
      if (advance) begin
         if (is_end) begin
            hist_in    = '0;
            seen_in    = '0;
            occ_in     = 16'd0;
            hit_in     = 1'b0;
            hit_pos_in = '0;
            ovf_in     = 1'b0;
         end else if (seen_ff == POS_LIMIT) begin
            ovf_in = 1'b1;
         end else begin
            hist_in = window;
            seen_in = seen_ff + 1'b1;
            if (match) begin
               occ_in = occ_next;
               if (cfg.search_mode == sofu_pkg::MODE_LAST) begin
                  hit_in     = 1'b1;
                  hit_pos_in = start;
               end else if (!hit_ff && occ_next == target) begin
                  hit_in     = 1'b1;
                  hit_pos_in = start;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         hist_ff      <= '0;
         seen_ff      <= '0;
         occ_ff       <= 16'd0;
         hit_ff       <= 1'b0;
         hit_pos_ff   <= '0;
         ovf_ff       <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         hist_ff      <= hist_in;
         seen_ff      <= seen_in;
         occ_ff       <= occ_in;
         hit_ff       <= hit_in;
         hit_pos_ff   <= hit_pos_in;
         ovf_ff       <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_word_ff <= req_word;
      end
      if (advance && is_end) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

endmodule

/* design/sofu_checker.sv */
`include "substring_occurrence_finder_unit_defines.svh"

module sofu_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input sofu_pkg::req_type req_word,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input sofu_pkg::rsp_type rsp_word
);

   `SOFU_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
   `SOFU_ASSERT(a_not_found_zero, rsp_valid && !rsp_word.found |-> rsp_word.start_position == '0)
   `SOFU_ASSERT(a_req_ready_free, (!rsp_valid || rsp_ready) |-> req_ready)
   `SOFU_ASSERT_ALWAYS(a_reset_idle, reset |=> !rsp_valid)

endmodule

bind substring_occurrence_finder_unit sofu_checker u_sofu_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_word  (req_word),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_word  (rsp_word)
);
